// ===== hw/rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types and constants for the stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready channels for the input items and the digest items.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha256_in_if;
    logic                 valid;
    logic                 ready;
    sha256_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sha256_out_if;
    logic                  valid;
    logic                  ready;
    sha256_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Hashes a byte stream and emits the eight digest words per message.
// ----------------------------------------------------------------------------
// Usage: the in channel takes one item per handshake: a byte (valid when
// has_byte is set) and an end_of_message flag. An item with neither flag is
// taken and does nothing. A byte that does not fill the block is stored.
// The 64th byte of a block starts a compression: the shared round unit runs
// one round per cycle, 64 rounds, and then folds the result into the chain.
// An end item pads the block and runs one or two compressions, then the
// digest goes out on the out channel as eight items, word 0 first, one per
// cycle while ready is high. A stalled receiver simply holds the current
// word; no new input is taken until the last word leaves. The block is not
// ready while compressing or emitting.
// Reset puts the chain at the initial hash values and empties the block.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sha256_in_if.sink   in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_PAD2  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];     // message schedule window, word 0 used next
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic        final_reg;      // compression belongs to a finished message
    logic        second_reg;     // a length-only block must follow
    logic        full_reg;       // compression of a full block of message bytes
    logic [2:0]  word_reg;
    logic [63:0] total_reg;

    // Shared round unit.
    logic [31:0] e, a, big1, big0, ch, maj, t1, t2, s0, s1, w_new;
    always_comb
    begin
        e    = v_reg[4];
        a    = v_reg[0];
        big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch   = (e & v_reg[5]) ^ (~e & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + ROUND_K[round_reg] + w_reg[0];
        big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj  = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
        s0   = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1   = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    logic take;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign take = in_ch.valid && in_ch.ready;

    assign out_ch.valid            = (state_reg == ST_EMIT);
    assign out_ch.data.digest_word = chain_reg[word_reg];
    assign out_ch.data.word_index  = word_reg;
    assign out_ch.data.last_word   = (word_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (in_ch.data.has_byte && fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (in_ch.data.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:
            begin
                // A full block that carried the end mark still needs its padding block.
                if (full_reg)
                    state_next = final_reg ? ST_PAD : ST_IDLE;
                else if (second_reg)
                    state_next = ST_PAD2;
                else
                    state_next = ST_EMIT;
            end
            ST_PAD2:  state_next = ST_ROUND;
            ST_EMIT:  if (out_ch.ready && word_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Bytes are written into the schedule window as big-endian words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            round_reg  <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            full_reg   <= 1'b0;
            word_reg   <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        logic [6:0] cnt;
                        cnt = {1'b0, fill_reg} + {6'd0, in_ch.data.has_byte};
                        if (in_ch.data.has_byte)
                        begin
                            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <=
                                in_ch.data.msg_byte;
                            fill_reg <= cnt[5:0];
                        end
                        total_reg <= bits_reg + {54'd0, cnt, 3'd0};
                        final_reg <= in_ch.data.end_of_message;
                        full_reg  <= in_ch.data.has_byte && (fill_reg == 6'd63);
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= chain_reg[i];
                    end
                end
                ST_PAD:
                begin
                    // Pad byte, zeros, and the length if it fits in this block.
                    for (int b = 0; b < 64; b++)
                    begin
                        if (b[5:0] == fill_reg)
                            w_reg[b/4][8*(3-b%4) +: 8] <= PAD_BYTE;
                        else if (b[5:0] > fill_reg && (b < 56 || fill_reg >= 6'd56))
                            w_reg[b/4][8*(3-b%4) +: 8] <= 8'd0;
                    end
                    second_reg <= (fill_reg >= 6'd56);
                    if (fill_reg < 6'd56)
                    begin
                        w_reg[14] <= total_reg[63:32];
                        w_reg[15] <= total_reg[31:0];
                    end
                end
                ST_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                        v_reg[i]     <= chain_reg[i] + v_reg[i];
                    end
                    round_reg <= '0;
                    if (full_reg)
                    begin
                        bits_reg <= bits_reg + BLOCK_BITS;
                        fill_reg <= '0;
                        full_reg <= 1'b0;
                    end
                    else if (!second_reg)
                        word_reg <= '0;
                end
                ST_PAD2:
                begin
                    second_reg <= 1'b0;
                    for (int i = 0; i < 14; i++)
                        w_reg[i] <= '0;
                    w_reg[14] <= total_reg[63:32];
                    w_reg[15] <= total_reg[31:0];
                end
                ST_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        word_reg <= word_reg + 3'd1;
                        if (word_reg == 3'd7)
                        begin
                            fill_reg  <= '0;
                            bits_reg  <= '0;
                            final_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= INIT_HASH[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== verif/sha256_stream_hasher_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Watches both channels, keeps its own SHA-256 state, and compares every
// digest item with the oldest predicted digest word.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    sha256_in_if      in_ch,
    sha256_out_if     out_ch,
    output int        fail_count,
    output int        pending_words,
    output int        digests_seen
);
    import sha256_pkg::*;

    logic [31:0] chain [8];
    logic [7:0]  block [64];
    logic [5:0]  fill;
    logic [63:0] bits_done;
    out_item_t   digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = INIT_HASH[i];
        fill = '0;
        bits_done = '0;
    endtask

    task automatic absorb_item(input in_item_t it);
        logic [63:0] total;
        out_item_t   word;
        if (it.has_byte)
        begin
            block[fill] = it.msg_byte;
            fill = fill + 6'd1;
            if (fill == 0)
            begin
                compress();
                bits_done = bits_done + BLOCK_BITS;
            end
        end
        if (!it.end_of_message)
            return;
        total = bits_done + {55'd0, fill, 3'd0};
        block[fill] = PAD_BYTE;
        for (int i = fill + 1; i < 64; i++)
            block[i] = 8'h00;
        if (fill >= 56)
        begin
            compress();
            for (int i = 0; i < 56; i++)
                block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            block[63-i] = total[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_q.push_back(word);
        end
        restart_hash();
    endtask

    assign pending_words = digest_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            restart_hash();
            digest_q.delete();
            fail_count   <= 0;
            digests_seen <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected digest item %h", out_ch.data);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (want.last_word)
                        digests_seen <= digests_seen + 1;
                    if (want !== out_ch.data)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("digest mismatch: expected word %h idx %0d last %b, got %h idx %0d last %b",
                                     want.digest_word, want.word_index, want.last_word,
                                     out_ch.data.digest_word, out_ch.data.word_index,
                                     out_ch.data.last_word);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                absorb_item(in_ch.data);
        end
    end
endmodule
`default_nettype wire

// ===== verif/sha256_stream_hasher_core_test.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams of assorted lengths with random gaps and stalls, and
// relies on the checker to predict and compare the digest words.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_core_test;
    import sha256_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_words;
    int   digests_seen;
    int   items_sent = 0;
    int   messages_sent = 0;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_stream_hasher_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    sha256_stream_hasher_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending_words(pending_words),
        .digests_seen(digests_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: waits a random number of cycles before taking each item.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = $urandom_range(0, 14);
            if (wait_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
            @(negedge clk);
        end
    end

    // Sends one item and waits for it to be accepted; gap_max 0 gives no idle.
    task automatic send_item(input logic [7:0] b, input logic hb, input logic eom,
                             input int gap_max);
        in_item_t it;
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        it.msg_byte = b;
        it.has_byte = hb;
        it.end_of_message = eom;
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
        if (eom)
            messages_sent++;
    endtask

    task automatic send_message(input int len, input int fill_kind, input int gap_max,
                                input logic tail_byte);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (fill_kind)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, gap_max);
            if (tail_byte && i == len - 1)
                send_item(b, 1'b1, 1'b1, gap_max);
            else
                send_item(b, 1'b1, 1'b0, gap_max);
        end
        if (!tail_byte || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1, gap_max);
    endtask

    initial
    begin
        int len;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty message, idle items, byte extremes, padding edges.
        send_item(8'hff, 1'b0, 1'b0, 0);
        send_item(8'h00, 1'b0, 1'b1, 0);
        send_message(1, 0, 0, 1'b1);
        send_message(1, 1, 3, 1'b0);
        send_message(3, 2, 0, 1'b1);
        // One padding block is the most; hold the sender until the digests are out.
        in_ch.valid <= 1'b0;
        while (pending_words > 0) @(negedge clk);
        send_message(55, 2, 14, 1'b1);
        send_message(56, 1, 2, 1'b0);
        send_message(64, 2, 0, 1'b1);

        // Random messages, mostly short, a few past one block.
        while (items_sent < 258)
        begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(54, 66);
                1: len = $urandom_range(65, 72);
                default: len = $urandom_range(0, 20);
            endcase
            if (len > 262 - items_sent)
                len = 262 - items_sent;
            send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2,
                         ($urandom_range(0, 3) == 0) ? 0 : 14, 1'($urandom));
        end
        in_ch.valid <= 1'b0;

        while (pending_words > 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Sent %0d items in %0d messages; %0d digests checked.",
                 items_sent, messages_sent, digests_seen);
        if (fail_count == 0 && pending_words == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timed out with %0d digest words outstanding.", pending_words);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
